[design/bca_pkg.sv]
// ----------------------------------------------------------------------------
// bca_pkg
// Types and constants shared by the BCD alarm clock modules.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int NumDigits = 6;

  // digit positions, hours tens first
  localparam int DHt = 0;
  localparam int DHu = 1;
  localparam int DMt = 2;
  localparam int DMu = 3;
  localparam int DSt = 4;
  localparam int DSu = 5;

  localparam logic [15:0] TpsReset = 16'd1000;
  localparam logic [15:0] SnoozeMax = 16'hFFFF;
  localparam logic [5:0] SecPerMin = 6'd60;

  localparam logic [3:0] UnitsLimit = 4'd10;
  localparam logic [3:0] TensLimit = 4'd6;
  localparam logic [3:0] HoursTensWrap = 4'd2;
  localparam logic [3:0] HoursUnitsWrap = 4'd4;

  // item kinds
  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_SET_TIME  = 3'd1,
    KIND_SET_ALARM = 3'd2,
    KIND_TOGGLE    = 3'd3,
    KIND_SNOOZE    = 3'd4
  } kind_e;

  typedef logic [3:0] digit_t;
  typedef digit_t [NumDigits-1:0] digits_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  hours_tens;
    logic [3:0]  hours_units;
    logic [2:0]  minutes_tens;
    logic [3:0]  minutes_units;
    logic [2:0]  seconds_tens;
    logic [3:0]  seconds_units;
    logic [10:0] snooze_minutes;
  } bca_in_t;

  typedef struct packed {
    logic [1:0] now_hours_tens;
    logic [3:0] now_hours_units;
    logic [2:0] now_minutes_tens;
    logic [3:0] now_minutes_units;
    logic [2:0] now_seconds_tens;
    logic [3:0] now_seconds_units;
    logic       time_is_set;
    logic       alarm_on;
    logic       alarm_ring;
    logic       snooze_ring;
  } bca_out_t;

  // architectural state of the clock
  typedef struct packed {
    digits_t     time_digits;
    logic        time_valid;
    digits_t     alarm_digits;
    logic        alarm_enabled;
    logic [15:0] prescale_count;
    logic [15:0] repeat_count;
    logic [15:0] snooze_count;
  } bca_state_t;

endpackage

[design/bca_step.sv]
// ----------------------------------------------------------------------------
// bca_step
// Next-state and result logic for one item: prescaler, digit carry cascade,
// alarm compare with repeat counter, and the set/toggle/snooze commands.
// ----------------------------------------------------------------------------
module bca_step (
  input  logic [15:0]         tps_i,
  input  bca_pkg::bca_state_t state_i,
  input  bca_pkg::bca_in_t    item_i,
  output bca_pkg::bca_state_t state_o,
  output bca_pkg::bca_out_t   result_o
);
  import bca_pkg::*;

  always_comb begin
    bca_state_t  s;
    digits_t     d;
    digits_t     ld;
    logic [15:0] p1;
    logic        fire;
    logic        a_ring;
    logic        s_ring;
    logic [16:0] load;
    logic [15:0] rep_base;

    s      = state_i;
    d      = state_i.time_digits;
    a_ring = 1'b0;
    s_ring = 1'b0;
    p1     = state_i.prescale_count + 16'd1;
    fire   = (p1 == tps_i);
    load   = 17'(item_i.snooze_minutes * SecPerMin);
    rep_base = (state_i.repeat_count == 16'd0) ? tps_i : state_i.repeat_count;

    // digits from the item, zero-extended to four bits
    ld[DHt] = {2'b00, item_i.hours_tens};
    ld[DHu] = item_i.hours_units;
    ld[DMt] = {1'b0, item_i.minutes_tens};
    ld[DMu] = item_i.minutes_units;
    ld[DSt] = {1'b0, item_i.seconds_tens};
    ld[DSu] = item_i.seconds_units;

    unique case (item_i.kind)
      KIND_TICK: begin
        // prescaler and seconds advance
        if (fire) begin
          d[DSu] = d[DSu] + 4'd1;
          s.prescale_count = 16'd0;
          if (state_i.snooze_count != 16'd0) begin
            s.snooze_count = state_i.snooze_count - 16'd1;
            s_ring = (state_i.snooze_count == 16'd1);
          end
        end else begin
          s.prescale_count = p1;
        end
        // carry cascade, exact-equality carries only
        if (d[DSu] == UnitsLimit) begin
          d[DSu] = '0;
          d[DSt] = d[DSt] + 4'd1;
        end
        if (d[DSt] == TensLimit) begin
          d[DSt] = '0;
          d[DMu] = d[DMu] + 4'd1;
        end
        if (d[DMu] == UnitsLimit) begin
          d[DMu] = '0;
          d[DMt] = d[DMt] + 4'd1;
        end
        if (d[DMt] == TensLimit) begin
          d[DMt] = '0;
          d[DHu] = d[DHu] + 4'd1;
        end
        if (d[DHu] == UnitsLimit) begin
          d[DHu] = '0;
          d[DHt] = d[DHt] + 4'd1;
        end
        // 24-hour wrap
        if (d[DHt] == HoursTensWrap && d[DHu] == HoursUnitsWrap) begin
          d[DHt] = '0;
          d[DHu] = '0;
        end
        s.time_digits = d;
        // alarm match, rings once per repeat period
        if (state_i.alarm_enabled && (d == state_i.alarm_digits)) begin
          a_ring = (state_i.repeat_count == 16'd0);
          s.repeat_count = rep_base - 16'd1;
        end
      end
      KIND_SET_TIME: begin
        s.time_digits = ld;
        s.time_valid  = 1'b1;
      end
      KIND_SET_ALARM: begin
        s.alarm_digits  = ld;
        s.alarm_enabled = 1'b1;
      end
      KIND_TOGGLE: begin
        s.alarm_enabled = !state_i.alarm_enabled;
      end
      KIND_SNOOZE: begin
        s.snooze_count = load[16] ? SnoozeMax : load[15:0];
      end
      default: begin
        // unused kinds leave the state alone
      end
    endcase

    state_o = s;

    result_o.now_hours_tens    = s.time_digits[DHt][1:0];
    result_o.now_hours_units   = s.time_digits[DHu];
    result_o.now_minutes_tens  = s.time_digits[DMt][2:0];
    result_o.now_minutes_units = s.time_digits[DMu];
    result_o.now_seconds_tens  = s.time_digits[DSt][2:0];
    result_o.now_seconds_units = s.time_digits[DSu];
    result_o.time_is_set       = s.time_valid;
    result_o.alarm_on          = s.alarm_enabled;
    result_o.alarm_ring        = a_ring;
    result_o.snooze_ring       = s_ring;
  end

endmodule

[design/bcd_alarm_clock.sv]
// ----------------------------------------------------------------------------
// bcd_alarm_clock
// Six-digit BCD time-of-day clock with alarm and snooze countdown.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one command
//   item: tick, set time, set alarm, toggle alarm enable, or start snooze.
//   Every item yields exactly one result item on the output channel
//   (out_valid_o / out_stall_i / out_item_o) with the time digits, the
//   time-set and alarm-enable flags and the two ring flags.
//   ticks_per_second is written through cfg_we_i / cfg_wdata_i while idle.
//   An accepted item lands in the input register, and its result is written
//   to the result register when the item leaves the input register.
//   Throughput: one item per cycle while the receiver does not stall, set
//   by the combinational cascade and compare between the two registers.
//   When the receiver stalls, the result register holds; one more item can
//   sit in the input register, after which in_stall_o is raised.
//   Reset clears the time, alarm, counters and flags, and loads
//   ticks_per_second with 1000.
// ----------------------------------------------------------------------------
module bcd_alarm_clock (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bca_pkg::bca_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bca_pkg::bca_out_t out_item_o
);
  import bca_pkg::*;

  logic [15:0] tps_q;
  bca_state_t  state_q, state_d;
  logic        s1_valid_q;
  bca_in_t     s1_item_q;
  logic        r_valid_q;
  bca_out_t    r_item_q, r_item_d;
  logic        r_ready;
  logic        s1_fire;
  logic        in_fire;

  // handshake between the two register stages
  assign r_ready    = !r_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && r_ready;
  assign in_stall_o = s1_valid_q && !r_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  bca_step u_step (
    .tps_i    (tps_q),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (r_item_d)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  // clock state, updated when an item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (r_ready) begin
      r_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      r_item_q <= r_item_d;
    end
  end

  assign out_valid_o = r_valid_q;
  assign out_item_o  = r_item_q;

  // state moves only with an item
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(state_q))
    else $error("clock state changed without an item");

  // a held item in the input register is not lost
  a_s1_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> s1_valid_q)
    else $error("stalled item dropped from input register");

  // commands other than tick never ring
  a_cmd_no_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_item_q.kind != KIND_TICK)
      |=> (!out_item_o.alarm_ring && !out_item_o.snooze_ring))
    else $error("ring flag on a non-tick item");

  // snooze ring leaves the countdown at zero
  a_snooze_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (!out_item_o.snooze_ring || state_q.snooze_count == 16'd0))
    else $error("snooze rang with countdown nonzero");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BCD alarm clock. A scoreboard keeps its own
// model of the time, alarm, prescaler, repeat and snooze counters, predicts
// the display for every accepted item and compares each result field by
// field. Random sender gaps and receiver stalls run throughout, except for
// one calm stretch, across several ticks-per-second settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bca_pkg::*;

  // item kinds the block ignores
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;
  localparam int unsigned BurstTicks = 62;

  // Scoreboard: clock model plus the queue of displays still due
  class alarm_clock_board;
    digits_t     now_digits;
    digits_t     alarm_digits;
    bit          time_valid;
    bit          alarm_en;
    logic [15:0] rate;
    logic [15:0] prescale;
    logic [15:0] rearm;
    logic [15:0] snooze;
    bca_out_t    due_displays[$];
    int unsigned faults;

    function new();
      now_digits   = '0;
      alarm_digits = '0;
      time_valid   = 1'b0;
      alarm_en     = 1'b0;
      rate         = TpsReset;
      prescale     = '0;
      rearm        = '0;
      snooze       = '0;
      faults       = 0;
    endfunction

    function int unsigned pending();
      return due_displays.size();
    endfunction

    // carry on exact equality only, next digit wraps mod 16
    function void carry(int from, logic [3:0] limit, int to);
      if (now_digits[from] == limit) begin
        now_digits[from] = '0;
        now_digits[to] = now_digits[to] + 4'd1;
      end
    endfunction

    function digits_t item_digits(bca_in_t c);
      digits_t d;
      d[DHt] = {2'b00, c.hours_tens};
      d[DHu] = c.hours_units;
      d[DMt] = {1'b0, c.minutes_tens};
      d[DMu] = c.minutes_units;
      d[DSt] = {1'b0, c.seconds_tens};
      d[DSu] = c.seconds_units;
      return d;
    endfunction

    // apply one item to the model and return the display it yields
    function bca_out_t advance_display(bca_in_t c);
      bca_out_t r;
      int unsigned load;
      r = '0;
      case (c.kind)
        KIND_TICK: begin
          prescale = prescale + 16'd1;
          if (prescale == rate) begin
            now_digits[DSu] = now_digits[DSu] + 4'd1;
            prescale = '0;
            if (snooze != '0) begin
              snooze = snooze - 16'd1;
              if (snooze == '0) r.snooze_ring = 1'b1;
            end
          end
          carry(DSu, UnitsLimit, DSt);
          carry(DSt, TensLimit, DMu);
          carry(DMu, UnitsLimit, DMt);
          carry(DMt, TensLimit, DHu);
          carry(DHu, UnitsLimit, DHt);
          if (now_digits[DHt] == HoursTensWrap && now_digits[DHu] == HoursUnitsWrap) begin
            now_digits[DHt] = '0;
            now_digits[DHu] = '0;
          end
          // ring once per rate ticks while the match holds
          if (alarm_en && now_digits == alarm_digits) begin
            if (rearm == '0) begin
              r.alarm_ring = 1'b1;
              rearm = rate;
            end
            rearm = rearm - 16'd1;
          end
        end
        KIND_SET_TIME: begin
          now_digits = item_digits(c);
          time_valid = 1'b1;
        end
        KIND_SET_ALARM: begin
          alarm_digits = item_digits(c);
          alarm_en = 1'b1;
        end
        KIND_TOGGLE: alarm_en = !alarm_en;
        KIND_SNOOZE: begin
          load = 32'(SecPerMin) * 32'(c.snooze_minutes);
          snooze = (load > 32'(SnoozeMax)) ? SnoozeMax : load[15:0];
        end
        default: ;
      endcase
      r.now_hours_tens    = now_digits[DHt][1:0];
      r.now_hours_units   = now_digits[DHu];
      r.now_minutes_tens  = now_digits[DMt][2:0];
      r.now_minutes_units = now_digits[DMu];
      r.now_seconds_tens  = now_digits[DSt][2:0];
      r.now_seconds_units = now_digits[DSu];
      r.time_is_set       = time_valid;
      r.alarm_on          = alarm_en;
      return r;
    endfunction

    function void note_command(bca_in_t c);
      due_displays.push_back(advance_display(c));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        faults++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_display(bca_out_t got);
      bca_out_t want;
      if (due_displays.size() == 0) begin
        faults++;
        $display("%0t: result expected none actual %h", $time, got);
        return;
      end
      want = due_displays.pop_front();
      compare_field("now_hours_tens", want.now_hours_tens, got.now_hours_tens);
      compare_field("now_hours_units", want.now_hours_units, got.now_hours_units);
      compare_field("now_minutes_tens", want.now_minutes_tens, got.now_minutes_tens);
      compare_field("now_minutes_units", want.now_minutes_units, got.now_minutes_units);
      compare_field("now_seconds_tens", want.now_seconds_tens, got.now_seconds_tens);
      compare_field("now_seconds_units", want.now_seconds_units, got.now_seconds_units);
      compare_field("time_is_set", want.time_is_set, got.time_is_set);
      compare_field("alarm_on", want.alarm_on, got.alarm_on);
      compare_field("alarm_ring", want.alarm_ring, got.alarm_ring);
      compare_field("snooze_ring", want.snooze_ring, got.snooze_ring);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  bca_in_t     in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  bca_out_t    out_item_o;

  bit calm = 1'b0;
  alarm_clock_board sb = new();

  bcd_alarm_clock dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls except in the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 15);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_display(out_item_o);
  end

  // item of the given kind with random filler in every other field
  function automatic bca_in_t noise_item(logic [2:0] k);
    logic [63:0] raw;
    bca_in_t c;
    raw = {$urandom, $urandom};
    c = raw[$bits(bca_in_t)-1:0];
    c.kind = k;
    return c;
  endfunction

  function automatic bca_in_t timed_item(logic [2:0] k, int ht, int hu, int mt, int mu,
                                         int st, int su);
    bca_in_t c;
    c = noise_item(k);
    c.hours_tens    = 2'(ht);
    c.hours_units   = 4'(hu);
    c.minutes_tens  = 3'(mt);
    c.minutes_units = 4'(mu);
    c.seconds_tens  = 3'(st);
    c.seconds_units = 4'(su);
    return c;
  endfunction

  // time near a rollover, or any bit pattern when wild
  function automatic bca_in_t rollover_item(logic [2:0] k);
    bca_in_t c;
    int ht;
    c = noise_item(k);
    if ($urandom_range(0, 9) == 0) return c;
    ht = $urandom_range(0, 2);
    c.hours_tens = 2'(ht);
    if (ht == 2) c.hours_units = 4'($urandom_range(0, 3));
    else c.hours_units = $urandom_range(0, 1) ? 4'd9 : 4'($urandom_range(0, 9));
    c.minutes_tens  = $urandom_range(0, 1) ? 3'd5 : 3'($urandom_range(0, 5));
    c.minutes_units = $urandom_range(0, 1) ? 4'd9 : 4'($urandom_range(0, 9));
    c.seconds_tens  = $urandom_range(0, 1) ? 3'd5 : 3'($urandom_range(0, 5));
    c.seconds_units = 4'($urandom_range(5, 9));
    return c;
  endfunction

  // alarm at the modeled time or up to three seconds ahead of it
  function automatic bca_in_t near_alarm_item();
    bca_in_t c;
    digits_t t;
    int unsigned su;
    t = sb.now_digits;
    su = t[DSu] + $urandom_range(0, 3);
    if (su > 9) su = t[DSu];
    c = timed_item(KIND_SET_ALARM, t[DHt], t[DHu], t[DMt], t[DMu], t[DSt], su);
    return c;
  endfunction

  function automatic bca_in_t random_command();
    bca_in_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) c = noise_item(KIND_TICK);
    else if (pick < 70) c = rollover_item(KIND_SET_TIME);
    else if (pick < 76) c = near_alarm_item();
    else if (pick < 78) c = rollover_item(KIND_SET_ALARM);
    else if (pick < 84) c = noise_item(KIND_TOGGLE);
    else if (pick < 92) begin
      c = noise_item(KIND_SNOOZE);
      if ($urandom_range(0, 1)) c.snooze_minutes = 11'($urandom_range(0, 2));
    end else c = noise_item(3'($urandom_range(KindSpareLo, KindSpareHi)));
    return c;
  endfunction

  task automatic send_command(bca_in_t c);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c);
  endtask

  // hold the sender until every display has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.rate = value;
  endtask

  // snooze of one minute, then enough ticks to see it ring at one tick per second
  task automatic snooze_burst();
    bca_in_t c;
    c = noise_item(KIND_SNOOZE);
    c.snooze_minutes = 11'd1;
    send_command(c);
    repeat (BurstTicks) send_command(noise_item(KIND_TICK));
  endtask

  task automatic run_phase(logic [15:0] value, int count, bit bursts);
    wait_drained();
    write_rate(value);
    for (int i = 0; i < count; i++) begin
      if (bursts && i == count / 2) snooze_burst();
      if (i == count / 3) wait_drained();
      send_command(random_command());
    end
  endtask

  // main sequence
  initial begin
    bca_in_t c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset rate: alarm at midnight with no time set
    send_command(noise_item(KIND_TICK));
    send_command(noise_item(KIND_TOGGLE));
    send_command(noise_item(KIND_TICK));
    send_command(noise_item(KIND_TICK));
    send_command(noise_item(KIND_TOGGLE));
    send_command(noise_item(KindSpareLo));
    send_command(noise_item(KindSpareHi));
    c = noise_item(KIND_SNOOZE);
    c.snooze_minutes = 11'd2047;
    send_command(c);
    c.snooze_minutes = 11'd1092;
    send_command(c);
    c.snooze_minutes = 11'd0;
    send_command(c);

    // directed, one tick per second: rollovers and out-of-range digits
    wait_drained();
    write_rate(16'd1);
    send_command(timed_item(KIND_SET_TIME, 2, 3, 5, 9, 5, 9));
    send_command(timed_item(KIND_SET_ALARM, 0, 0, 0, 0, 0, 0));
    send_command(noise_item(KIND_TICK));
    send_command(noise_item(KIND_TICK));
    send_command(timed_item(KIND_SET_TIME, 0, 9, 5, 9, 5, 9));
    send_command(noise_item(KIND_TICK));
    send_command(timed_item(KIND_SET_TIME, 1, 9, 5, 9, 5, 9));
    send_command(noise_item(KIND_TICK));
    send_command(timed_item(KIND_SET_TIME, 3, 15, 7, 15, 7, 15));
    send_command(noise_item(KIND_TICK));
    send_command(noise_item(KIND_TICK));
    send_command(timed_item(KIND_SET_ALARM, 3, 15, 7, 15, 7, 15));
    send_command(noise_item(KindSpareLo + 3'd1));

    // random phases over several rates
    run_phase(16'd1, 100, 1'b1);
    run_phase(16'd3, 100, 1'b0);
    run_phase(16'd2, 100, 1'b0);
    run_phase(16'd0, 30, 1'b0);
    run_phase(16'd65535, 30, 1'b0);
    calm = 1'b1;
    run_phase(16'd1, 120, 1'b1);
    calm = 1'b0;
    run_phase(16'd7, 60, 1'b0);
    run_phase(16'd1, 60, 1'b0);

    wait_drained();
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
